[rtl/core/cia_pkg.sv]
// Shared constants, the lens class codes and elaboration-time helpers
// for the circle intersection area pipeline. No dependencies.
`timescale 1ns / 1ps

package cia_pkg;

    localparam int COORD_BITS_DEF   = 21;
    localparam int FRAC_BITS_DEF    = 8;
    localparam int CORDIC_STEPS_DEF = 32;

    localparam int ROOT_BITS = 62;
    localparam int ANGLE_W   = 64;
    localparam int AREA_BITS = 50;
    localparam int AREA_W    = ((AREA_BITS + 7) / 8) * 8;

    localparam logic [AREA_BITS-1:0]      AREA_MAX = {AREA_BITS{1'b1}};
    localparam logic signed [ANGLE_W-1:0] PI_Q60   = 64'sh3243F6A8885A308D;
    localparam logic signed [ANGLE_W-1:0] PI_HALF  = PI_Q60 >>> 1;

    typedef enum logic [1:0] {
        CLS_NEG  = 2'd0,
        CLS_CONT = 2'd1,
        CLS_SEP  = 2'd2,
        CLS_LENS = 2'd3
    } cls_t;

    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int j = 63; j >= 0; j--) begin
            rem = {rem[63:0], num[j]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[j] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Truncated odd power series of atan(2^-i) in Q60 radians.
    function automatic logic signed [ANGLE_W-1:0] step_angle(input int i);
        logic signed [ANGLE_W-1:0] acc;
        logic [63:0] term;
        int e;
        acc = '0;
        e = 60 - i;
        if (i == 0) begin
            return PI_Q60 >>> 2;
        end
        for (int k = 0; k < 64; k++) begin
            if (e >= 0) begin
                term = div_u64(64'd1 << e, 64'(2 * k + 1));
                if ((k & 1) != 0) begin
                    acc = acc - $signed(term);
                end
                else begin
                    acc = acc + $signed(term);
                end
                e = e - 2 * i;
            end
        end
        return acc;
    endfunction

endpackage

[rtl/core/cia_sqrt.sv]
// Two-lane pipelined floor square root, one root bit per register stage.
// Depends on cia_pkg for the root width.
`timescale 1ns / 1ps

module cia_sqrt #(
    parameter int ROOT_BITS = cia_pkg::ROOT_BITS,
    parameter int SIDE_W    = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [2*ROOT_BITS-1:0] in_rad_a,
    input  logic [2*ROOT_BITS-1:0] in_rad_b,
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_valid,
    output logic [ROOT_BITS-1:0]   root_a,
    output logic [ROOT_BITS-1:0]   root_b,
    output logic [SIDE_W-1:0]      out_side
);

    localparam int RW = 2 * ROOT_BITS;
    localparam logic [RW-1:0] ONE_R = RW'(1);
    localparam logic [ROOT_BITS-1:0] ONE_Q = ROOT_BITS'(1);

    logic                 valid_reg  [ROOT_BITS];
    logic [RW-1:0]        rem_a_reg  [ROOT_BITS];
    logic [RW-1:0]        rem_b_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] root_a_reg [ROOT_BITS];
    logic [ROOT_BITS-1:0] root_b_reg [ROOT_BITS];
    logic [SIDE_W-1:0]    side_reg   [ROOT_BITS];

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
        localparam int B = ROOT_BITS - 1 - k;

        logic                 v_in;
        logic [RW-1:0]        ra_in;
        logic [RW-1:0]        rb_in;
        logic [ROOT_BITS-1:0] qa_in;
        logic [ROOT_BITS-1:0] qb_in;
        logic [SIDE_W-1:0]    s_in;
        logic [RW-1:0]        ta;
        logic [RW-1:0]        tb;
        logic                 ga;
        logic                 gb;

        if (k == 0) begin : g_first
            assign v_in  = in_valid;
            assign ra_in = in_rad_a;
            assign rb_in = in_rad_b;
            assign qa_in = '0;
            assign qb_in = '0;
            assign s_in  = in_side;
        end
        else begin : g_next
            assign v_in  = valid_reg[k-1];
            assign ra_in = rem_a_reg[k-1];
            assign rb_in = rem_b_reg[k-1];
            assign qa_in = root_a_reg[k-1];
            assign qb_in = root_b_reg[k-1];
            assign s_in  = side_reg[k-1];
        end

        assign ta = (RW'(qa_in) << (B + 1)) | (ONE_R << (2 * B));
        assign tb = (RW'(qb_in) << (B + 1)) | (ONE_R << (2 * B));
        assign ga = (ra_in >= ta);
        assign gb = (rb_in >= tb);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_a_reg[k]  <= ga ? (ra_in - ta) : ra_in;
                rem_b_reg[k]  <= gb ? (rb_in - tb) : rb_in;
                root_a_reg[k] <= ga ? (qa_in | (ONE_Q << B)) : qa_in;
                root_b_reg[k] <= gb ? (qb_in | (ONE_Q << B)) : qb_in;
                side_reg[k]   <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_BITS-1];
    assign root_a    = root_a_reg[ROOT_BITS-1];
    assign root_b    = root_b_reg[ROOT_BITS-1];
    assign out_side  = side_reg[ROOT_BITS-1];

endmodule

[rtl/core/cia_cordic.sv]
// Two-lane pipelined vectoring CORDIC giving Q60 angles, with a quadrant
// pre-rotation stage. Depends on cia_pkg for the step angles and pi.
`timescale 1ns / 1ps

module cia_cordic #(
    parameter int STEPS  = cia_pkg::CORDIC_STEPS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [cia_pkg::ANGLE_W-1:0]  x_a,
    input  logic signed [cia_pkg::ANGLE_W-1:0]  x_b,
    input  logic signed [cia_pkg::ANGLE_W-1:0]  y_in,
    input  logic [SIDE_W-1:0]                   in_side,
    output logic                                out_valid,
    output logic signed [cia_pkg::ANGLE_W-1:0]  z_a,
    output logic signed [cia_pkg::ANGLE_W-1:0]  z_b,
    output logic [SIDE_W-1:0]                   out_side
);

    localparam int W = cia_pkg::ANGLE_W;

    logic              valid_reg [STEPS+1];
    logic signed [W-1:0] xa_reg  [STEPS+1];
    logic signed [W-1:0] ya_reg  [STEPS+1];
    logic signed [W-1:0] za_reg  [STEPS+1];
    logic signed [W-1:0] xb_reg  [STEPS+1];
    logic signed [W-1:0] yb_reg  [STEPS+1];
    logic signed [W-1:0] zb_reg  [STEPS+1];
    logic [SIDE_W-1:0]   side_reg [STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg[0]   <= x_a[W-1] ? y_in : x_a;
            ya_reg[0]   <= x_a[W-1] ? -x_a : y_in;
            za_reg[0]   <= x_a[W-1] ? cia_pkg::PI_HALF : '0;
            xb_reg[0]   <= x_b[W-1] ? y_in : x_b;
            yb_reg[0]   <= x_b[W-1] ? -x_b : y_in;
            zb_reg[0]   <= x_b[W-1] ? cia_pkg::PI_HALF : '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        localparam int I = k - 1;
        localparam logic signed [W-1:0] ANG = cia_pkg::step_angle(I);

        logic signed [W-1:0] xsa;
        logic signed [W-1:0] ysa;
        logic signed [W-1:0] xsb;
        logic signed [W-1:0] ysb;

        assign xsa = xa_reg[k-1] >>> I;
        assign ysa = ya_reg[k-1] >>> I;
        assign xsb = xb_reg[k-1] >>> I;
        assign ysb = yb_reg[k-1] >>> I;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!ya_reg[k-1][W-1])
                begin
                    xa_reg[k] <= xa_reg[k-1] + ysa;
                    ya_reg[k] <= ya_reg[k-1] - xsa;
                    za_reg[k] <= za_reg[k-1] + ANG;
                end
                else
                begin
                    xa_reg[k] <= xa_reg[k-1] - ysa;
                    ya_reg[k] <= ya_reg[k-1] + xsa;
                    za_reg[k] <= za_reg[k-1] - ANG;
                end
                if (!yb_reg[k-1][W-1])
                begin
                    xb_reg[k] <= xb_reg[k-1] + ysb;
                    yb_reg[k] <= yb_reg[k-1] - xsb;
                    zb_reg[k] <= zb_reg[k-1] + ANG;
                end
                else
                begin
                    xb_reg[k] <= xb_reg[k-1] - ysb;
                    yb_reg[k] <= yb_reg[k-1] + xsb;
                    zb_reg[k] <= zb_reg[k-1] - ANG;
                end
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign z_a       = za_reg[STEPS];
    assign z_b       = zb_reg[STEPS];
    assign out_side  = side_reg[STEPS];

endmodule

[rtl/core/circle_intersection_area.sv]
// Top level of the circle intersection area pipeline: exact integer tests,
// lens arithmetic, output register and skid stage. Uses cia_pkg, cia_sqrt, cia_cordic.
// One item is accepted per cycle while the skid stage is empty; s_axis_tready
// is low while the skid stage holds a result. The depth is mostly set by the
// 62 root-bit stages of the square root and the CORDIC stages.
// Reset clears only the valid bits of every stage, the output and the skid stage.
`timescale 1ns / 1ps

module circle_intersection_area #(
    parameter int COORD_BITS   = cia_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS    = cia_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = cia_pkg::CORDIC_STEPS_DEF,
    localparam int IN_W        = ((6 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // center_ax, center_ay, radius_a, center_bx, center_by, radius_b, zero fill
    input  logic [IN_W-1:0]             s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // overlap_area, zero fill
    output logic [cia_pkg::AREA_W-1:0]  m_axis_tdata,
    // status
    output logic [0:0]                  m_axis_tuser
);

    localparam int C    = COORD_BITS;
    localparam int AG   = 58 - 2 * C;
    localparam int RQW  = 2 * C - 2;
    localparam int UW   = 2 * C + 3;
    localparam int PPW  = C + 30;
    localparam int AW   = 2 * C + 60;
    localparam int FIN  = AW + 1;
    localparam int QW   = 4 * C;
    localparam int RB   = cia_pkg::ROOT_BITS;
    localparam int RTW  = 2 * RB;
    localparam int AB   = cia_pkg::AREA_BITS;
    localparam int S1W  = 2 + AB + 2 * UW + 2 * RQW;
    localparam int S2W  = 2 + AB + 2 * RQW + RB;
    localparam logic [30:0] PI_LO = cia_pkg::PI_Q60[30:0];
    localparam logic [30:0] PI_HI = cia_pkg::PI_Q60[61:31];

    function automatic logic [AW-1:0] join4(input logic [PPW-1:0] p00, input logic [PPW-1:0] p01,
                                            input logic [PPW-1:0] p10, input logic [PPW-1:0] p11);
        return AW'(p00) + (AW'(p01) << 31) + (AW'(p10) << (C - 1)) + (AW'(p11) << (C + 30));
    endfunction

    function automatic logic [AB-1:0] round_sat(input logic [FIN-1:0] v);
        logic [FIN-1:0] r;
        r = v + (FIN'(1) << (59 - FRAC_BITS));
        r = r >> (60 - FRAC_BITS);
        if (r > FIN'(cia_pkg::AREA_MAX)) begin
            return cia_pkg::AREA_MAX;
        end
        return r[AB-1:0];
    endfunction

    logic en;

    // Stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic va_reg, vb_reg, vc_reg, vd_reg, ve_reg;

    // Stage 1: captured fields
    logic [6*C-1:0] s1_data_reg;
    logic signed [C-1:0] ax, ay, ra, bx, by, rb;

    // Stage 2
    logic signed [C:0] s2_dx_reg, s2_dy_reg;
    logic [C-2:0] s2_r1_reg, s2_r2_reg;
    logic s2_neg_reg;

    // Stage 3
    logic signed [2*C+1:0] dx_sq, dy_sq;
    logic signed [C-1:0] rd_w;
    logic signed [2*C-1:0] rd_sq;
    logic [C-1:0] rs_w;
    logic [C-2:0] rmin_w;
    logic [2*C:0] s3_dx2_reg, s3_dy2_reg;
    logic [RQW-1:0] s3_rd2_reg, s3_r1sq_reg, s3_r2sq_reg, s3_rmsq_reg;
    logic [2*C-1:0] s3_rs2_reg;
    logic s3_neg_reg;

    // Stage 4
    logic [2*C+1:0] s4_d2_reg;
    logic signed [2*C-2:0] s4_rdiff_reg;
    logic [RQW-1:0] s4_rd2_reg, s4_r1sq_reg, s4_r2sq_reg;
    logic [2*C-1:0] s4_rs2_reg;
    logic [PPW-1:0] s4_cp00_reg, s4_cp01_reg, s4_cp10_reg, s4_cp11_reg;
    logic s4_neg_reg;

    // Stage 5
    cia_pkg::cls_t s5_cls_next, s5_cls_reg;
    logic [2*C+1:0] p_full, m_full;
    logic [2*C-1:0] s5_p_reg, s5_m_reg;
    logic signed [UW-1:0] s5_u1_reg, s5_u2_reg;
    logic [RQW-1:0] s5_r1sq_reg, s5_r2sq_reg;
    logic [AW-1:0] s5_cprod_reg;

    // Stage 6
    cia_pkg::cls_t s6_cls_reg;
    logic [2*C-1:0] s6_pp00_reg, s6_pp01_reg, s6_pp10_reg, s6_pp11_reg;
    logic [AB-1:0] s6_cont_reg;
    logic signed [UW-1:0] s6_u1_reg, s6_u2_reg;
    logic [RQW-1:0] s6_r1sq_reg, s6_r2sq_reg;

    // Stage 7
    cia_pkg::cls_t s7_cls_reg;
    logic [QW-1:0] s7_q_reg;
    logic [AB-1:0] s7_cont_reg;
    logic signed [UW-1:0] s7_u1_reg, s7_u2_reg;
    logic [RQW-1:0] s7_r1sq_reg, s7_r2sq_reg;

    // Square root
    logic [RTW-1:0] sq_in_a, sq_in_b;
    logic [S1W-1:0] sq_side_in, sq_side_out;
    logic sq_valid;
    logic [RB-1:0] sq_sg, sq_sa;
    logic [1:0] sq_cls;
    logic [AB-1:0] sq_cont;
    logic signed [UW-1:0] sq_u1, sq_u2;
    logic [RQW-1:0] sq_r1sq, sq_r2sq;

    // CORDIC
    logic signed [cia_pkg::ANGLE_W-1:0] cd_xa, cd_xb, cd_y, cd_za, cd_zb;
    logic [S2W-1:0] cd_side_in, cd_side_out;
    logic cd_valid;
    logic [1:0] cd_cls;
    logic [AB-1:0] cd_cont;
    logic [RQW-1:0] cd_r1sq, cd_r2sq;
    logic [RB-1:0] cd_sa;
    logic [61:0] th1, th2;

    // Stages A to E
    cia_pkg::cls_t sa_cls_reg, sb_cls_reg, sc_cls_reg, sd_cls_reg;
    logic [AB-1:0] sa_cont_reg, sb_cont_reg, sc_cont_reg, sd_cont_reg;
    logic [RB-1:0] sa_sa_reg, sb_sa_reg;
    logic [PPW-1:0] sa_a00_reg, sa_a01_reg, sa_a10_reg, sa_a11_reg;
    logic [PPW-1:0] sa_b00_reg, sa_b01_reg, sa_b10_reg, sa_b11_reg;
    logic [AW-1:0] sb_arc1_reg, sb_arc2_reg;
    logic [FIN-1:0] sc_arcs_reg, sc_chord_reg;
    logic [FIN-1:0] sd_diff_reg;
    logic sd_zero_reg;
    logic [AB-1:0] se_area_next, se_area_reg;
    logic se_status_reg;

    // Output register and skid stage
    logic out_valid_reg, out_valid_next;
    logic [AB-1:0] out_area_reg, out_area_next;
    logic out_status_reg, out_status_next;
    logic skid_valid_reg, skid_valid_next;
    logic [AB-1:0] skid_area_reg, skid_area_next;
    logic skid_status_reg, skid_status_next;

    assign en = !skid_valid_reg;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            va_reg <= cd_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
        end
    end

    assign ax = s1_data_reg[C-1:0];
    assign ay = s1_data_reg[2*C-1:C];
    assign ra = s1_data_reg[3*C-1:2*C];
    assign bx = s1_data_reg[4*C-1:3*C];
    assign by = s1_data_reg[5*C-1:4*C];
    assign rb = s1_data_reg[6*C-1:5*C];

    assign dx_sq  = s2_dx_reg * s2_dx_reg;
    assign dy_sq  = s2_dy_reg * s2_dy_reg;
    assign rd_w   = $signed({1'b0, s2_r1_reg}) - $signed({1'b0, s2_r2_reg});
    assign rd_sq  = rd_w * rd_w;
    assign rs_w   = {1'b0, s2_r1_reg} + {1'b0, s2_r2_reg};
    assign rmin_w = (s2_r1_reg < s2_r2_reg) ? s2_r1_reg : s2_r2_reg;

    assign p_full = {2'b00, s4_rs2_reg} - s4_d2_reg;
    assign m_full = s4_d2_reg - {4'b0000, s4_rd2_reg};

    always_comb
    begin
        if (s4_neg_reg)
        begin
            s5_cls_next = cia_pkg::CLS_NEG;
        end
        else if (s4_d2_reg <= {4'b0000, s4_rd2_reg})
        begin
            s5_cls_next = cia_pkg::CLS_CONT;
        end
        else if (s4_d2_reg >= {2'b00, s4_rs2_reg})
        begin
            s5_cls_next = cia_pkg::CLS_SEP;
        end
        else
        begin
            s5_cls_next = cia_pkg::CLS_LENS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_data_reg <= s_axis_tdata[6*C-1:0];

            s2_dx_reg  <= $signed({bx[C-1], bx}) - $signed({ax[C-1], ax});
            s2_dy_reg  <= $signed({by[C-1], by}) - $signed({ay[C-1], ay});
            s2_r1_reg  <= ra[C-2:0];
            s2_r2_reg  <= rb[C-2:0];
            s2_neg_reg <= ra[C-1] | rb[C-1];

            s3_dx2_reg  <= dx_sq[2*C:0];
            s3_dy2_reg  <= dy_sq[2*C:0];
            s3_rd2_reg  <= rd_sq[RQW-1:0];
            s3_rs2_reg  <= rs_w * rs_w;
            s3_r1sq_reg <= s2_r1_reg * s2_r1_reg;
            s3_r2sq_reg <= s2_r2_reg * s2_r2_reg;
            s3_rmsq_reg <= rmin_w * rmin_w;
            s3_neg_reg  <= s2_neg_reg;

            s4_d2_reg    <= {1'b0, s3_dx2_reg} + {1'b0, s3_dy2_reg};
            s4_rdiff_reg <= $signed({1'b0, s3_r1sq_reg}) - $signed({1'b0, s3_r2sq_reg});
            s4_rd2_reg   <= s3_rd2_reg;
            s4_rs2_reg   <= s3_rs2_reg;
            s4_r1sq_reg  <= s3_r1sq_reg;
            s4_r2sq_reg  <= s3_r2sq_reg;
            s4_cp00_reg  <= PPW'(s3_rmsq_reg[C-2:0]) * PPW'(PI_LO);
            s4_cp01_reg  <= PPW'(s3_rmsq_reg[C-2:0]) * PPW'(PI_HI);
            s4_cp10_reg  <= PPW'(s3_rmsq_reg[2*C-3:C-1]) * PPW'(PI_LO);
            s4_cp11_reg  <= PPW'(s3_rmsq_reg[2*C-3:C-1]) * PPW'(PI_HI);
            s4_neg_reg   <= s3_neg_reg;

            s5_cls_reg   <= s5_cls_next;
            s5_p_reg     <= p_full[2*C-1:0];
            s5_m_reg     <= m_full[2*C-1:0];
            s5_u1_reg    <= $signed({1'b0, s4_d2_reg}) + s4_rdiff_reg;
            s5_u2_reg    <= $signed({1'b0, s4_d2_reg}) - s4_rdiff_reg;
            s5_r1sq_reg  <= s4_r1sq_reg;
            s5_r2sq_reg  <= s4_r2sq_reg;
            s5_cprod_reg <= join4(s4_cp00_reg, s4_cp01_reg, s4_cp10_reg, s4_cp11_reg);

            s6_cls_reg  <= s5_cls_reg;
            s6_pp00_reg <= (2*C)'(s5_p_reg[C-1:0]) * (2*C)'(s5_m_reg[C-1:0]);
            s6_pp01_reg <= (2*C)'(s5_p_reg[C-1:0]) * (2*C)'(s5_m_reg[2*C-1:C]);
            s6_pp10_reg <= (2*C)'(s5_p_reg[2*C-1:C]) * (2*C)'(s5_m_reg[C-1:0]);
            s6_pp11_reg <= (2*C)'(s5_p_reg[2*C-1:C]) * (2*C)'(s5_m_reg[2*C-1:C]);
            s6_cont_reg <= round_sat(FIN'(s5_cprod_reg));
            s6_u1_reg   <= s5_u1_reg;
            s6_u2_reg   <= s5_u2_reg;
            s6_r1sq_reg <= s5_r1sq_reg;
            s6_r2sq_reg <= s5_r2sq_reg;

            s7_cls_reg  <= s6_cls_reg;
            s7_q_reg    <= QW'(s6_pp00_reg) + (QW'(s6_pp01_reg) << C)
                         + (QW'(s6_pp10_reg) << C) + (QW'(s6_pp11_reg) << (2 * C));
            s7_cont_reg <= s6_cont_reg;
            s7_u1_reg   <= s6_u1_reg;
            s7_u2_reg   <= s6_u2_reg;
            s7_r1sq_reg <= s6_r1sq_reg;
            s7_r2sq_reg <= s6_r2sq_reg;
        end
    end

    assign sq_in_a    = RTW'(s7_q_reg) << (2 * AG);
    assign sq_in_b    = RTW'(s7_q_reg) << (2 * FRAC_BITS);
    assign sq_side_in = {s7_cls_reg, s7_cont_reg, s7_u1_reg, s7_u2_reg, s7_r1sq_reg, s7_r2sq_reg};

    cia_sqrt #(
        .ROOT_BITS (RB),
        .SIDE_W    (S1W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .in_rad_a  (sq_in_a),
        .in_rad_b  (sq_in_b),
        .in_side   (sq_side_in),
        .out_valid (sq_valid),
        .root_a    (sq_sg),
        .root_b    (sq_sa),
        .out_side  (sq_side_out)
    );

    assign {sq_cls, sq_cont, sq_u1, sq_u2, sq_r1sq, sq_r2sq} = sq_side_out;

    assign cd_xa      = cia_pkg::ANGLE_W'(sq_u1) <<< AG;
    assign cd_xb      = cia_pkg::ANGLE_W'(sq_u2) <<< AG;
    assign cd_y       = $signed(cia_pkg::ANGLE_W'(sq_sg));
    assign cd_side_in = {sq_cls, sq_cont, sq_r1sq, sq_r2sq, sq_sa};

    cia_cordic #(
        .STEPS     (CORDIC_STEPS),
        .SIDE_W    (S2W)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .x_a       (cd_xa),
        .x_b       (cd_xb),
        .y_in      (cd_y),
        .in_side   (cd_side_in),
        .out_valid (cd_valid),
        .z_a       (cd_za),
        .z_b       (cd_zb),
        .out_side  (cd_side_out)
    );

    assign {cd_cls, cd_cont, cd_r1sq, cd_r2sq, cd_sa} = cd_side_out;

    assign th1 = cd_za[cia_pkg::ANGLE_W-1] ? '0 : cd_za[61:0];
    assign th2 = cd_zb[cia_pkg::ANGLE_W-1] ? '0 : cd_zb[61:0];

    always_comb
    begin
        unique case (sd_cls_reg)
            cia_pkg::CLS_NEG:  se_area_next = '0;
            cia_pkg::CLS_CONT: se_area_next = sd_cont_reg;
            cia_pkg::CLS_SEP:  se_area_next = '0;
            cia_pkg::CLS_LENS: se_area_next = sd_zero_reg ? '0 : round_sat(sd_diff_reg);
            default:           se_area_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_cls_reg  <= cia_pkg::cls_t'(cd_cls);
            sa_cont_reg <= cd_cont;
            sa_sa_reg   <= cd_sa;
            sa_a00_reg  <= PPW'(cd_r1sq[C-2:0]) * PPW'(th1[30:0]);
            sa_a01_reg  <= PPW'(cd_r1sq[C-2:0]) * PPW'(th1[61:31]);
            sa_a10_reg  <= PPW'(cd_r1sq[2*C-3:C-1]) * PPW'(th1[30:0]);
            sa_a11_reg  <= PPW'(cd_r1sq[2*C-3:C-1]) * PPW'(th1[61:31]);
            sa_b00_reg  <= PPW'(cd_r2sq[C-2:0]) * PPW'(th2[30:0]);
            sa_b01_reg  <= PPW'(cd_r2sq[C-2:0]) * PPW'(th2[61:31]);
            sa_b10_reg  <= PPW'(cd_r2sq[2*C-3:C-1]) * PPW'(th2[30:0]);
            sa_b11_reg  <= PPW'(cd_r2sq[2*C-3:C-1]) * PPW'(th2[61:31]);

            sb_cls_reg  <= sa_cls_reg;
            sb_cont_reg <= sa_cont_reg;
            sb_sa_reg   <= sa_sa_reg;
            sb_arc1_reg <= join4(sa_a00_reg, sa_a01_reg, sa_a10_reg, sa_a11_reg);
            sb_arc2_reg <= join4(sa_b00_reg, sa_b01_reg, sa_b10_reg, sa_b11_reg);

            sc_cls_reg   <= sb_cls_reg;
            sc_cont_reg  <= sb_cont_reg;
            sc_arcs_reg  <= FIN'(sb_arc1_reg) + FIN'(sb_arc2_reg);
            sc_chord_reg <= FIN'(sb_sa_reg) << (59 - FRAC_BITS);

            sd_cls_reg  <= sc_cls_reg;
            sd_cont_reg <= sc_cont_reg;
            sd_zero_reg <= (sc_arcs_reg <= sc_chord_reg);
            sd_diff_reg <= sc_arcs_reg - sc_chord_reg;

            se_area_reg   <= se_area_next;
            se_status_reg <= (sd_cls_reg == cia_pkg::CLS_NEG);
        end
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_area_next    = out_area_reg;
        out_status_next  = out_status_reg;
        skid_valid_next  = skid_valid_reg;
        skid_area_next   = skid_area_reg;
        skid_status_next = skid_status_reg;
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                out_area_next   = skid_area_reg;
                out_status_next = skid_status_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (ve_reg)
        begin
            if (!out_valid_reg || m_axis_tready)
            begin
                out_valid_next  = 1'b1;
                out_area_next   = se_area_reg;
                out_status_next = se_status_reg;
            end
            else
            begin
                skid_valid_next  = 1'b1;
                skid_area_next   = se_area_reg;
                skid_status_next = se_status_reg;
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_area_reg    <= out_area_next;
        out_status_reg  <= out_status_next;
        skid_area_reg   <= skid_area_next;
        skid_status_reg <= skid_status_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {{(cia_pkg::AREA_W - AB){1'b0}}, out_area_reg};
    assign m_axis_tuser[0] = out_status_reg;

endmodule
